FILE: rtl/chunked_ring_buffer_pointers_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef CHUNKED_RING_BUFFER_POINTERS_TOP_ASSERT_SVH
`define CHUNKED_RING_BUFFER_POINTERS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRBP_ASSERT_HOLDS(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRBP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crbp_pkg.sv
package crbp_pkg;

  localparam int MAX_CHUNKS   = 16;
  localparam int IDX_W        = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CHUNK_BYTES  = 32768;
  localparam int LVL_W        = 16;
  localparam int CNT_W        = 16;
  localparam int NCH_W        = 5;
  localparam int CLOSE_MARGIN = 1024;
  localparam int OUT_PAD_W    = 6;

  localparam logic [LVL_W:0] CHUNK_BYTES_X  = (LVL_W + 1)'(CHUNK_BYTES);
  localparam logic [LVL_W:0] CLOSE_MARGIN_X = (LVL_W + 1)'(CLOSE_MARGIN);

  // operation codes carried on tuser
  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_FLUSH   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_STATE = 2'd1;
  localparam logic [1:0] STAT_COUNT = 2'd2;

  typedef struct packed {
    logic             filled;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // first member is the top bits of tdata
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [1:0]           status;
    logic                 chunk_closed;
    logic [NCH_W-1:0]     filled_chunks;
    logic [LVL_W-1:0]     wr_space;
    logic [LVL_W-1:0]     wr_offset;
    logic [IDX_W-1:0]     wr_chunk;
    logic                 wr_ready;
    logic [LVL_W-1:0]     rd_avail;
    logic [LVL_W-1:0]     rd_offset;
    logic [IDX_W-1:0]     rd_chunk;
    logic                 rd_ready;
  } result_t;

  localparam int OUT_W = $bits(result_t);

endpackage

FILE: rtl/crbp_ram.sv
module crbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/chunked_ring_buffer_pointers_top.sv
// Chunked ring buffer pointer manager.
//
// Input stream (s_axis_*): one transaction per operation. tuser carries the
// operation (query, fill, consume, flush), tdata the byte count.
// Output stream (m_axis_*): one transaction per accepted operation, showing
// the read and write chunk positions after the operation, the number of
// filled chunks, whether a fill closed its chunk, and a status code.
// Configuration channel (cfg_*): write the ring size at any time the block
// is idle; zero acts as one chunk, values above the chunk limit act as it.
//
// Per-chunk state lives in two mirrored single-port-write RAMs (one read at
// the read index, one at the write index). The entries are read at the
// accepting edge; the result then reaches m_axis through the execute, look
// and report states: modify and write back, read the updated entries, then
// load the output register. One operation is in flight at a time: a new one
// is accepted only once the previous one has left the report step.
// A new operation is accepted while the previous result waits in the output
// register; if the receiver stalls, the next result holds in the report step.
// Reset (and a flush) clears every chunk through per-entry valid bits, so no
// clearing pass is needed and the block is ready right after reset.
module chunked_ring_buffer_pointers_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: ring size
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [crbp_pkg::NCH_W-1:0]  cfg_data_i,
  // operations in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [crbp_pkg::CNT_W-1:0]  s_axis_tdata,   // count
  input  logic [1:0]                  s_axis_tuser,   // op
  // results out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // rd_ready, rd_chunk, rd_offset, rd_avail, wr_ready, wr_chunk, wr_offset,
  // wr_space, filled_chunks, chunk_closed, status, zero pad
  output logic [crbp_pkg::OUT_W-1:0]  m_axis_tdata
);

  import crbp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_LOOK   = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [1:0]            op_q;
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]      wr_idx_q, wr_idx_d;
  logic [NCH_W-1:0]      nfill_q, nfill_d;
  logic [NCH_W-1:0]      nch_q;
  logic [MAX_CHUNKS-1:0] vld_q, vld_d;
  logic                  closed_q, closed_d;
  logic [1:0]            status_q, status_d;
  logic                  out_valid_q;
  result_t               out_q;

  logic                  accept;
  logic                  load_out;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  entry_t                wdata;
  logic [ENTRY_W-1:0]    rdata_rd, rdata_wr;
  entry_t                ent_rd, ent_wr;
  logic [NCH_W-1:0]      ring;
  logic [NCH_W-1:0]      rd_nx, wr_nx;
  logic [LVL_W:0]        space, avail, hsum, lsum, left;
  logic                  close;
  result_t               res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Entry RAMs: identical contents, one read port each.
  crbp_ram #(.Width(ENTRY_W), .Depth(MAX_CHUNKS)) u_ram_rd (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata_rd)
  );

  crbp_ram #(.Width(ENTRY_W), .Depth(MAX_CHUNKS)) u_ram_wr (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (wr_idx_q),
    .rdata_o (rdata_wr)
  );

  // An entry never written since reset or flush reads as zero.
  assign ent_rd = vld_q[rd_idx_q] ? entry_t'(rdata_rd) : '0;
  assign ent_wr = vld_q[wr_idx_q] ? entry_t'(rdata_wr) : '0;

  // Clamp the ring size and wrap the indices against it.
  always_comb begin
    if (nch_q == '0) begin
      ring = NCH_W'(1);
    end else if (nch_q > NCH_W'(MAX_CHUNKS)) begin
      ring = NCH_W'(MAX_CHUNKS);
    end else begin
      ring = nch_q;
    end
    rd_nx = NCH_W'(rd_idx_q) + NCH_W'(1);
    wr_nx = NCH_W'(wr_idx_q) + NCH_W'(1);
    if (rd_nx >= ring) rd_nx = '0;
    if (wr_nx >= ring) wr_nx = '0;
  end

  assign space = CHUNK_BYTES_X - {1'b0, ent_wr.level};
  assign avail = {1'b0, ent_rd.level} - {1'b0, ent_rd.offset};
  assign hsum  = {1'b0, ent_wr.level} + {1'b0, count_q};
  assign lsum  = {1'b0, ent_rd.offset} + {1'b0, count_q};
  assign left  = CHUNK_BYTES_X - hsum;
  assign close = (left < CLOSE_MARGIN_X) || ((count_q == '0) && (hsum != '0));

  // Read-modify-write of the chunk the operation targets.
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    nfill_d  = nfill_q;
    vld_d    = vld_q;
    closed_d = closed_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = wr_idx_q;
    wdata    = ent_wr;
    load_out = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        closed_d = 1'b0;
        status_d = STAT_OK;
        state_d  = ST_LOOK;
        case (op_q)
          OP_FILL: begin
            if (ent_wr.filled) begin
              status_d = STAT_STATE;
            end else if ({1'b0, count_q} > space) begin
              status_d = STAT_COUNT;
            end else begin
              we           = 1'b1;
              waddr        = wr_idx_q;
              wdata.offset = ent_wr.offset;
              wdata.level  = hsum[LVL_W-1:0];
              wdata.filled = close;
              vld_d[wr_idx_q] = 1'b1;
              if (close) begin
                closed_d = 1'b1;
                wr_idx_d = wr_nx[IDX_W-1:0];
                nfill_d  = nfill_q + NCH_W'(1);
              end
            end
          end
          OP_CONSUME: begin
            if (!ent_rd.filled) begin
              status_d = STAT_STATE;
            end else if ({1'b0, count_q} > avail) begin
              status_d = STAT_COUNT;
            end else begin
              we    = 1'b1;
              waddr = rd_idx_q;
              vld_d[rd_idx_q] = 1'b1;
              if (lsum == {1'b0, ent_rd.level}) begin
                // chunk drained: free it and move on
                wdata    = '0;
                rd_idx_d = rd_nx[IDX_W-1:0];
                nfill_d  = nfill_q - NCH_W'(1);
              end else begin
                wdata        = ent_rd;
                wdata.offset = lsum[LVL_W-1:0];
              end
            end
          end
          OP_FLUSH: begin
            vld_d    = '0;
            rd_idx_d = '0;
            wr_idx_d = '0;
            nfill_d  = '0;
          end
          default: begin
          end
        endcase
      end
      ST_LOOK: begin
        // RAM reads of the updated entries are in flight
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result as seen after the operation.
  always_comb begin
    res               = '0;
    res.rd_ready      = ent_rd.filled;
    res.rd_chunk      = rd_idx_q;
    res.rd_offset     = ent_rd.offset;
    res.rd_avail      = ent_rd.filled ? avail[LVL_W-1:0] : '0;
    res.wr_ready      = !ent_wr.filled;
    res.wr_chunk      = wr_idx_q;
    res.wr_offset     = ent_wr.level;
    res.wr_space      = ent_wr.filled ? '0 : space[LVL_W-1:0];
    res.filled_chunks = nfill_q;
    res.chunk_closed  = closed_q;
    res.status        = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      nfill_q     <= '0;
      nch_q       <= NCH_W'(MAX_CHUNKS);
      vld_q       <= '0;
      closed_q    <= 1'b0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      nfill_q  <= nfill_d;
      vld_q    <= vld_d;
      closed_q <= closed_d;
      status_q <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        nch_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the operation, hold the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      count_q <= s_axis_tdata;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: rtl/crbp_checker.sv
`include "chunked_ring_buffer_pointers_top_assert.svh"

module crbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [crbp_pkg::NCH_W-1:0]  cfg_data_i,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [crbp_pkg::CNT_W-1:0]  s_axis_tdata,
  input logic [1:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [crbp_pkg::OUT_W-1:0]  m_axis_tdata
);

  import crbp_pkg::*;

  result_t        r;
  logic [LVL_W:0] wr_total;
  logic           in_xfer;
  logic           cfg_xfer;

  assign r        = result_t'(m_axis_tdata);
  assign wr_total = {1'b0, r.wr_offset} + {1'b0, r.wr_space};
  assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == s_axis_tuser)
                    && (s_axis_tdata == s_axis_tdata);
  assign cfg_xfer = cfg_valid_i && cfg_ready_o && (cfg_data_i == cfg_data_i);

  // one operation in flight: no back-to-back acceptance
  `CRBP_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_xfer, !s_axis_tready, "operation accepted while busy")

  // stalled result holds
  `CRBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // a closing fill always succeeds
  `CRBP_ASSERT_HOLDS(a_close_ok, clk_i, rst_ni, m_axis_tvalid && r.chunk_closed, r.status == STAT_OK, "closed chunk with error status")

  // an open write chunk accounts for every byte of the chunk
  `CRBP_ASSERT_HOLDS(a_wr_span, clk_i, rst_ni, m_axis_tvalid && r.wr_ready && !cfg_xfer, wr_total == CHUNK_BYTES_X, "write offset and space disagree")

  // nothing readable in an unfilled read chunk
  `CRBP_ASSERT_HOLDS(a_rd_empty, clk_i, rst_ni, m_axis_tvalid && !r.rd_ready, r.rd_avail == '0, "bytes available in unfilled chunk")

endmodule

bind chunked_ring_buffer_pointers_top crbp_checker u_crbp_checker (.*);
